>>> rtl/core/sst_pkg.sv
// ----------------------------------------------------------------------------
// sst_pkg
// Shared types, codes and defaults of the sorted set table.
// ----------------------------------------------------------------------------
package sst_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int KEY_BITS_DEF = 32;

	// payload widths fixed by the word format
	localparam int KEY_W  = 32;
	localparam int HELD_W = 7;

	// fan-in of one step of the hit reduction
	localparam int FANIN     = 8;
	localparam int LOG_FANIN = 3;

	typedef enum logic [1:0] {
		REQ_SEARCH = 2'd0,
		REQ_INSERT = 2'd1,
		REQ_DELETE = 2'd2,
		REQ_CLEAR  = 2'd3
	} req_type_t;

	typedef enum logic [1:0] {
		ST_DONE   = 2'd0,
		ST_DUP    = 2'd1,
		ST_ABSENT = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_RED,
		S_COMMIT
	} state_t;

	// broadcast to every cell of the chain
	typedef struct packed {
		logic cmp_en;
		logic ins_en;
		logic del_en;
	} cell_ctrl_t;

endpackage

>>> rtl/core/sst_req_if.sv
// ----------------------------------------------------------------------------
// sst_req_if
// Request channel: operation code and key, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sst_req_if;
	logic                     valid;
	logic                     ready;
	logic [1:0]               req_type;
	logic [sst_pkg::KEY_W-1:0] key;

	modport source (output valid, output req_type, output key, input ready);
	modport sink   (input valid, input req_type, input key, output ready);
endinterface

>>> rtl/core/sst_rsp_if.sv
// ----------------------------------------------------------------------------
// sst_rsp_if
// Response channel: hit flag, status and key count, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sst_rsp_if;
	logic                      valid;
	logic                      ready;
	logic                      hit;
	logic [1:0]                status;
	logic [sst_pkg::HELD_W-1:0] entries_held;

	modport source (output valid, output hit, output status, output entries_held,
		input ready);
	modport sink   (input valid, input hit, input status, input entries_held,
		output ready);
endinterface

>>> rtl/core/sst_cell.sv
// ----------------------------------------------------------------------------
// sst_cell
// One slot of the sorted chain: holds a key, compares it with the broadcast
// key and shifts toward or away from its neighbors on insert and delete.
// ----------------------------------------------------------------------------
module sst_cell #(
	parameter int KEY_BITS = sst_pkg::KEY_BITS_DEF
) (
	input  logic                clk,
	input  sst_pkg::cell_ctrl_t ctrl,
	input  logic                occ,
	input  logic [KEY_BITS-1:0] key_in,
	input  logic                prev_lt,
	input  logic [KEY_BITS-1:0] prev_key,
	input  logic [KEY_BITS-1:0] next_key,
	output logic [KEY_BITS-1:0] key_q,
	output logic                lt_q,
	output logic                eq
);

	assign eq = occ && (key_q == key_in);

	// lt_q marks slots left of the insertion point; it stays valid until commit
	always_ff @(posedge clk) begin
		if (ctrl.cmp_en) begin
			lt_q <= occ && (key_q < key_in);
		end else if (ctrl.ins_en) begin
			if (!lt_q) begin
				key_q <= prev_lt ? key_in : prev_key;
			end
		end else if (ctrl.del_en) begin
			if (!lt_q) begin
				key_q <= next_key;
			end
		end
	end

endmodule

>>> rtl/core/sst_hit_reduce.sv
// ----------------------------------------------------------------------------
// sst_hit_reduce
// Iterated OR reduction of the per-cell match flags, FANIN to one per step.
// ----------------------------------------------------------------------------
module sst_hit_reduce #(
	parameter int WIDTH = sst_pkg::CAPACITY_DEF
) (
	input  logic             clk,
	input  logic             load,
	input  logic             step,
	input  logic [WIDTH-1:0] vec_in,
	output logic             found
);

	logic [WIDTH-1:0] red_q;
	logic [WIDTH-1:0] red_d;

	always_comb begin
		red_d = red_q;
		if (load) begin
			red_d = vec_in;
		end else if (step) begin
			red_d = '0;
			for (int j = 0; j < WIDTH; j++) begin
				for (int b = 0; b < sst_pkg::FANIN; b++) begin
					if (j * sst_pkg::FANIN + b < WIDTH) begin
						red_d[j] = red_d[j] | red_q[j * sst_pkg::FANIN + b];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		red_q <= red_d;
	end

	assign found = red_q[0];

endmodule

>>> rtl/core/sorted_set_table.sv
// Sorted set table: a chain of CAPACITY key cells kept in ascending order.
// An accepted request passes the compare, RED_STEPS reduction and commit states;
// RED_STEPS = ceil(log8(CAPACITY)) (2 at CAPACITY 64).
// A new request is taken only in the idle state, after the compare, the match
// reduction and commit shift of the last; a held response stalls the next commit.
// Reset empties the set at once; cell contents are not cleared.
// ----------------------------------------------------------------------------
// sorted_set_table
// Search, insert, delete and clear on a set of distinct sorted keys.
// ----------------------------------------------------------------------------
module sorted_set_table #(
	parameter int CAPACITY = sst_pkg::CAPACITY_DEF,
	parameter int KEY_BITS = sst_pkg::KEY_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	sst_req_if.sink  req,
	sst_rsp_if.source rsp
);

	localparam int CNT_W     = $clog2(CAPACITY + 1);
	localparam int RED_STEPS = ($clog2(CAPACITY) + sst_pkg::LOG_FANIN - 1) / sst_pkg::LOG_FANIN;
	localparam int RS_W      = $clog2(RED_STEPS + 1);

	sst_pkg::state_t     state_q, state_d;
	sst_pkg::req_type_t  req_type_q;
	sst_pkg::cell_ctrl_t ctrl;

	logic [KEY_BITS-1:0]         key_req_q;
	logic [KEY_BITS+31:0]        key_ext;
	logic [CNT_W-1:0]            cnt_q, cnt_d;
	logic [CNT_W+6:0]            cnt_ext;
	logic [RS_W-1:0]             red_cnt_q;
	logic                        rsp_valid_q;
	logic                        hit_q;
	logic [1:0]                  status_q;
	logic [sst_pkg::HELD_W-1:0]  held_q;

	logic                        out_free;
	logic                        commit_go;
	logic                        red_step;
	logic                        found;
	logic                        full;
	logic                        ins_take;
	logic                        del_take;
	logic                        hit_d;
	sst_pkg::status_t            status_d;

	logic [CAPACITY-1:0]         occ;
	logic [CAPACITY-1:0]         lt;
	logic [CAPACITY-1:0]         eq;
	logic [KEY_BITS-1:0]         cell_key [CAPACITY];

	// keys wider than the port are zero-extended, narrower ones truncated
	assign key_ext = (KEY_BITS + 32)'(req.key);

	// ---------------- cell chain ----------------
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                prev_lt;
		logic [KEY_BITS-1:0] prev_key;
		logic [KEY_BITS-1:0] next_key;

		assign occ[i] = cnt_q > CNT_W'(i);

		if (i == 0) begin : g_head
			assign prev_lt  = 1'b1;
			assign prev_key = key_req_q;
		end else begin : g_mid
			assign prev_lt  = lt[i-1];
			assign prev_key = cell_key[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign next_key = key_req_q;
		end else begin : g_body
			assign next_key = cell_key[i+1];
		end

		sst_cell #(
			.KEY_BITS (KEY_BITS)
		) u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.occ      (occ[i]),
			.key_in   (key_req_q),
			.prev_lt  (prev_lt),
			.prev_key (prev_key),
			.next_key (next_key),
			.key_q    (cell_key[i]),
			.lt_q     (lt[i]),
			.eq       (eq[i])
		);
	end

	sst_hit_reduce #(
		.WIDTH (CAPACITY)
	) u_reduce (
		.clk    (clk),
		.load   (ctrl.cmp_en),
		.step   (red_step),
		.vec_in (eq),
		.found  (found)
	);

	// ---------------- control ----------------
	assign out_free = !rsp_valid_q || rsp.ready;
	assign full     = cnt_q == CNT_W'(CAPACITY);

	always_comb begin
		state_d = state_q;
		case (state_q)
			sst_pkg::S_IDLE:   if (req.valid) state_d = sst_pkg::S_CMP;
			sst_pkg::S_CMP:    state_d = sst_pkg::S_RED;
			sst_pkg::S_RED:    if (red_cnt_q == RS_W'(1)) state_d = sst_pkg::S_COMMIT;
			sst_pkg::S_COMMIT: if (out_free) state_d = sst_pkg::S_IDLE;
			default:           state_d = sst_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		req.ready   = 1'b0;
		red_step    = 1'b0;
		commit_go   = 1'b0;
		ctrl.cmp_en = 1'b0;
		case (state_q)
			sst_pkg::S_IDLE:   req.ready   = 1'b1;
			sst_pkg::S_CMP:    ctrl.cmp_en = 1'b1;
			sst_pkg::S_RED:    red_step    = 1'b1;
			sst_pkg::S_COMMIT: commit_go   = out_free;
			default: ;
		endcase
		ctrl.ins_en = commit_go && ins_take;
		ctrl.del_en = commit_go && del_take;
	end

	// result of the operation, valid in the commit state
	always_comb begin
		hit_d    = 1'b0;
		status_d = sst_pkg::ST_DONE;
		ins_take = 1'b0;
		del_take = 1'b0;
		cnt_d    = cnt_q;
		case (req_type_q)
			sst_pkg::REQ_SEARCH: begin
				hit_d    = found;
				status_d = found ? sst_pkg::ST_DONE : sst_pkg::ST_ABSENT;
			end
			sst_pkg::REQ_INSERT: begin
				if (found) begin
					status_d = sst_pkg::ST_DUP;
				end else if (full) begin
					status_d = sst_pkg::ST_FULL;
				end else begin
					hit_d    = 1'b1;
					ins_take = 1'b1;
					cnt_d    = cnt_q + CNT_W'(1);
				end
			end
			sst_pkg::REQ_DELETE: begin
				if (!found) begin
					status_d = sst_pkg::ST_ABSENT;
				end else begin
					hit_d    = 1'b1;
					del_take = 1'b1;
					cnt_d    = cnt_q - CNT_W'(1);
				end
			end
			sst_pkg::REQ_CLEAR: begin
				hit_d = 1'b1;
				cnt_d = '0;
			end
			default: ;
		endcase
	end

	assign cnt_ext = (CNT_W + 7)'(cnt_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sst_pkg::S_IDLE;
			cnt_q       <= '0;
			red_cnt_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctrl.cmp_en) begin
				red_cnt_q <= RS_W'(RED_STEPS);
			end else if (red_step) begin
				red_cnt_q <= red_cnt_q - RS_W'(1);
			end
			if (commit_go) begin
				cnt_q       <= cnt_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_type_q <= sst_pkg::req_type_t'(req.req_type);
			key_req_q  <= key_ext[KEY_BITS-1:0];
		end
		if (commit_go) begin
			hit_q    <= hit_d;
			status_q <= status_d;
			held_q   <= cnt_ext[sst_pkg::HELD_W-1:0];
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.hit          = hit_q;
	assign rsp.status       = status_q;
	assign rsp.entries_held = held_q;

	// ---------------- assertions ----------------
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY))
		else $error("key count above capacity");

	a_ins_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.ins_en |=> cnt_q == $past(cnt_q) + CNT_W'(1))
		else $error("insert did not grow the set by one");

	a_del_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.del_en |=> cnt_q == $past(cnt_q) - CNT_W'(1))
		else $error("delete did not shrink the set by one");

	a_rsp_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == sst_pkg::S_COMMIT)
		else $error("response word raised outside commit");

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the sorted set table against a behavioral copy of the set: every
// request is predicted when accepted and each response is compared field by
// field, with random idle and stall on both channels.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int CAP          = sst_pkg::CAPACITY_DEF;
	localparam int KB           = sst_pkg::KEY_BITS_DEF;
	localparam int KW           = sst_pkg::KEY_W;
	localparam int HW           = sst_pkg::HELD_W;
	localparam int LIMIT_CYCLES = 400000;
	localparam int SETTLE       = 20;
	localparam int LONG_HOLD    = 300;
	localparam int HOLD_AT      = 500;
	localparam int POOL_N       = 80;
	localparam int RAND_ITEMS   = 1700;

	typedef struct {
		sst_pkg::req_type_t op;
		logic [KW-1:0]      key;
		bit                 drain;
	} request_t;

	typedef struct {
		logic             hit;
		sst_pkg::status_t status;
		logic [HW-1:0]    held;
	} outcome_t;

	logic clk;
	logic arst_n;

	sst_req_if req_ch ();
	sst_rsp_if rsp_ch ();

	sorted_set_table #(
		.CAPACITY(CAP),
		.KEY_BITS(KB)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	request_t      pend_q[$];
	outcome_t      want_q[$];
	logic [KW-1:0] set_keys[CAP];
	int            set_size = 0;
	int            fail_count = 0;
	int            cycle_count = 0;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	task automatic report_mismatch(string what, logic [KW-1:0] got,
		logic [KW-1:0] want);
		$display("mismatch %0s: got %0h want %0h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	// apply one request to the shadow set and return the response it yields
	function automatic outcome_t set_apply(sst_pkg::req_type_t op, logic [KW-1:0] raw);
		logic [63:0]   mask;
		logic [KW-1:0] k;
		int            pos;
		bit            present;
		outcome_t      r;
		mask = (KB >= 64) ? '1 : ((64'd1 << KB) - 64'd1);
		k = raw & mask[KW-1:0];
		pos = 0;
		while (pos < set_size && set_keys[pos] < k)
			pos++;
		present = (pos < set_size) && (set_keys[pos] == k);
		r.hit = 1'b0;
		r.status = sst_pkg::ST_DONE;
		case (op)
			sst_pkg::REQ_SEARCH: begin
				r.hit = present;
				r.status = present ? sst_pkg::ST_DONE : sst_pkg::ST_ABSENT;
			end
			sst_pkg::REQ_INSERT: begin
				if (present) begin
					r.status = sst_pkg::ST_DUP;
				end else if (set_size >= CAP) begin
					r.status = sst_pkg::ST_FULL;
				end else begin
					for (int i = set_size; i > pos; i--)
						set_keys[i] = set_keys[i-1];
					set_keys[pos] = k;
					set_size++;
					r.hit = 1'b1;
				end
			end
			sst_pkg::REQ_DELETE: begin
				if (!present) begin
					r.status = sst_pkg::ST_ABSENT;
				end else begin
					for (int i = pos; i + 1 < set_size; i++)
						set_keys[i] = set_keys[i+1];
					set_size--;
					r.hit = 1'b1;
				end
			end
			default: begin
				set_size = 0;
				r.hit = 1'b1;
			end
		endcase
		r.held = set_size[HW-1:0];
		return r;
	endfunction

	task automatic queue_req(sst_pkg::req_type_t op, logic [KW-1:0] k, bit drain = 1'b0);
		request_t t;
		t.op = op;
		t.key = k;
		t.drain = drain;
		pend_q.insert(pend_q.size(), t);
	endtask

	// request driver
	request_t cur;
	int       gap_left;
	bit       send_burst;

	always @(posedge clk or negedge arst_n) begin
		logic nxt_valid;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.req_type <= sst_pkg::REQ_SEARCH;
			req_ch.key <= '0;
			gap_left = 0;
			send_burst = 1'b0;
		end else begin
			if (req_ch.valid && req_ch.ready)
				want_q.insert(want_q.size(), set_apply(cur.op, cur.key));
			if (!req_ch.valid || req_ch.ready) begin
				nxt_valid = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end else if (pend_q.size() > 0 &&
					!(pend_q[0].drain && want_q.size() > 0)) begin
					cur = pend_q.pop_front();
					nxt_valid = 1'b1;
					if ($urandom_range(0, 79) == 0)
						send_burst = !send_burst;
					gap_left = send_burst ? 0 : $urandom_range(0, 12);
				end
				req_ch.valid <= nxt_valid;
				if (nxt_valid) begin
					req_ch.req_type <= cur.op;
					req_ch.key <= cur.key;
				end
			end
		end
	end

	// response monitor
	int       stall_left;
	int       rsp_count;
	bit       take_burst;
	outcome_t got_w;

	always @(posedge clk or negedge arst_n) begin
		logic nxt_ready;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall_left = 0;
			rsp_count = 0;
			take_burst = 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (want_q.size() == 0) begin
					report_mismatch("word with no request pending",
						KW'(rsp_ch.entries_held), '0);
				end else begin
					got_w = want_q.pop_front();
					if (rsp_ch.hit !== got_w.hit)
						report_mismatch("hit", KW'(rsp_ch.hit), KW'(got_w.hit));
					if (rsp_ch.status !== got_w.status)
						report_mismatch("status", KW'(rsp_ch.status), KW'(got_w.status));
					if (rsp_ch.entries_held !== got_w.held)
						report_mismatch("entries_held", KW'(rsp_ch.entries_held),
							KW'(got_w.held));
				end
				rsp_count++;
				if (rsp_count == HOLD_AT) begin
					// long back-pressure: the table must stall its request side
					stall_left = LONG_HOLD;
				end else begin
					if ($urandom_range(0, 79) == 0)
						take_burst = !take_burst;
					stall_left = take_burst ? 0 : $urandom_range(0, 12);
				end
			end
			nxt_ready = 1'b1;
			if (stall_left > 0) begin
				stall_left--;
				nxt_ready = 1'b0;
			end
			rsp_ch.ready <= nxt_ready;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("sorted_set_table test failed");
			$finish;
		end
	end

	initial begin
		logic [KW-1:0]      pool[POOL_N];
		logic [KW-1:0]      fill_keys[CAP];
		int                 mode;
		int                 r;
		sst_pkg::req_type_t op;
		logic [KW-1:0]      k;

		arst_n = 1'b0;

		// directed: empty table, extremes, neighbors, first/last/middle delete
		queue_req(sst_pkg::REQ_SEARCH, 32'h0000_0000);
		queue_req(sst_pkg::REQ_DELETE, 32'h0000_0005);
		queue_req(sst_pkg::REQ_CLEAR,  32'h0000_0000);
		queue_req(sst_pkg::REQ_INSERT, 32'h8000_0000);
		queue_req(sst_pkg::REQ_INSERT, 32'h0000_0000);
		queue_req(sst_pkg::REQ_INSERT, 32'hFFFF_FFFF);
		queue_req(sst_pkg::REQ_INSERT, 32'h8000_0000);
		queue_req(sst_pkg::REQ_SEARCH, 32'h0000_0000);
		queue_req(sst_pkg::REQ_SEARCH, 32'hFFFF_FFFF);
		queue_req(sst_pkg::REQ_SEARCH, 32'h0000_0001);
		queue_req(sst_pkg::REQ_INSERT, 32'h0000_0001);
		queue_req(sst_pkg::REQ_INSERT, 32'hFFFF_FFFE);
		queue_req(sst_pkg::REQ_INSERT, 32'h7FFF_FFFF);
		queue_req(sst_pkg::REQ_DELETE, 32'h0000_0000);
		queue_req(sst_pkg::REQ_DELETE, 32'hFFFF_FFFF);
		queue_req(sst_pkg::REQ_DELETE, 32'h7FFF_FFFF);
		queue_req(sst_pkg::REQ_DELETE, 32'h0000_0000);
		queue_req(sst_pkg::REQ_SEARCH, 32'h8000_0000);
		queue_req(sst_pkg::REQ_CLEAR,  32'hFFFF_FFFF);
		queue_req(sst_pkg::REQ_SEARCH, 32'h8000_0000);
		queue_req(sst_pkg::REQ_INSERT, 32'h5555_5555);
		queue_req(sst_pkg::REQ_INSERT, 32'hAAAA_AAAA);

		// fill to capacity, then duplicate and overflow on a full table
		queue_req(sst_pkg::REQ_CLEAR, $urandom, 1'b1);
		for (int i = 0; i < CAP; i++) begin
			fill_keys[i] = {26'($urandom_range(0, (1 << 26) - 1)), i[5:0]};
			queue_req(sst_pkg::REQ_INSERT, fill_keys[i]);
		end
		queue_req(sst_pkg::REQ_INSERT, fill_keys[$urandom_range(0, CAP - 1)]);
		queue_req(sst_pkg::REQ_INSERT, 32'hFFFF_FFC0);
		queue_req(sst_pkg::REQ_SEARCH, fill_keys[0]);
		queue_req(sst_pkg::REQ_DELETE, fill_keys[7]);
		queue_req(sst_pkg::REQ_INSERT, 32'hFFFF_FFC0);
		queue_req(sst_pkg::REQ_INSERT, 32'h0000_0040);
		queue_req(sst_pkg::REQ_CLEAR, $urandom);

		// random: keys mostly from a small pool so the set grows, hits and fills
		pool[0] = '0;
		pool[1] = '1;
		for (int i = 2; i < POOL_N; i++)
			pool[i] = $urandom;
		mode = 0;
		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (n % 250 == 0)
				mode = $urandom_range(0, 2);
			r = $urandom_range(0, 999);
			if (r >= 995)
				op = sst_pkg::REQ_CLEAR;
			else if (mode == 0)
				op = (r < 800) ? sst_pkg::REQ_INSERT :
					(r < 920) ? sst_pkg::REQ_SEARCH : sst_pkg::REQ_DELETE;
			else if (mode == 1)
				op = (r < 200) ? sst_pkg::REQ_INSERT :
					(r < 400) ? sst_pkg::REQ_SEARCH : sst_pkg::REQ_DELETE;
			else
				op = (r < 400) ? sst_pkg::REQ_INSERT :
					(r < 700) ? sst_pkg::REQ_SEARCH : sst_pkg::REQ_DELETE;
			k = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, POOL_N - 1)]
				: $urandom;
			queue_req(op, k, n == 850);
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(negedge clk);
		while (pend_q.size() != 0 || req_ch.valid || want_q.size() != 0);
		repeat (SETTLE) @(negedge clk);

		if (fail_count == 0)
			$display("sorted_set_table test passed");
		else
			$display("sorted_set_table test failed");
		$finish;
	end

endmodule

>>> sorted_set_table.f
rtl/core/sst_pkg.sv
rtl/core/sst_req_if.sv
rtl/core/sst_rsp_if.sv
rtl/core/sst_cell.sv
rtl/core/sst_hit_reduce.sv
rtl/core/sorted_set_table.sv
verif/tb_top.sv
